// File: hw/rtl/rim_pkg.sv
package rim_pkg;

	// field widths
	localparam int COORD_BITS = 12;
	localparam int COEF_BITS  = 16;
	localparam int OUT_BITS   = COORD_BITS - 1;

	// trig scale is a power of two, so the divide is a biased shift
	localparam int TRIG_SHIFT = 10;
	localparam int TRIG_SCALE = 1 << TRIG_SHIFT;

	// datapath widths
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = COEF_BITS + DIFF_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int QUO_BITS  = SUM_BITS - TRIG_SHIFT;
	localparam int POS_BITS  = QUO_BITS + 1;

	// largest source size that still fits the output fields
	localparam int MAX_SIZE = 1 << OUT_BITS;

	// register file
	localparam int NUM_REGS  = 8;
	localparam int IDX_BITS  = $clog2(NUM_REGS);
	localparam int ADDR_BITS = IDX_BITS + 2;
	localparam int DATA_BITS = 32;

	typedef enum logic [IDX_BITS-1:0] {
		REG_COS_COEF     = 3'd0,
		REG_SIN_COEF     = 3'd1,
		REG_DST_CENTER_X = 3'd2,
		REG_DST_CENTER_Y = 3'd3,
		REG_SRC_CENTER_X = 3'd4,
		REG_SRC_CENTER_Y = 3'd5,
		REG_SRC_WIDTH    = 3'd6,
		REG_SRC_HEIGHT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_BITS-1:0]  cos_coef;
		logic [COEF_BITS-1:0]  sin_coef;
		logic [COORD_BITS-1:0] dst_center_x;
		logic [COORD_BITS-1:0] dst_center_y;
		logic [COORD_BITS-1:0] src_center_x;
		logic [COORD_BITS-1:0] src_center_y;
		logic [COORD_BITS-1:0] src_width;
		logic [COORD_BITS-1:0] src_height;
	} rim_cfg_t;

endpackage

// File: hw/rtl/rim_cfg_regs.sv
module rim_cfg_regs
	import rim_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output rim_cfg_t             cfg
);

	rim_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_coef     <= COEF_BITS'(TRIG_SCALE);
			cfg_q.sin_coef     <= '0;
			cfg_q.dst_center_x <= '0;
			cfg_q.dst_center_y <= '0;
			cfg_q.src_center_x <= '0;
			cfg_q.src_center_y <= '0;
			cfg_q.src_width    <= '0;
			cfg_q.src_height   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_COS_COEF:     cfg_q.cos_coef     <= pwdata[COEF_BITS-1:0];
				REG_SIN_COEF:     cfg_q.sin_coef     <= pwdata[COEF_BITS-1:0];
				REG_DST_CENTER_X: cfg_q.dst_center_x <= pwdata[COORD_BITS-1:0];
				REG_DST_CENTER_Y: cfg_q.dst_center_y <= pwdata[COORD_BITS-1:0];
				REG_SRC_CENTER_X: cfg_q.src_center_x <= pwdata[COORD_BITS-1:0];
				REG_SRC_CENTER_Y: cfg_q.src_center_y <= pwdata[COORD_BITS-1:0];
				REG_SRC_WIDTH:    cfg_q.src_width    <= pwdata[COORD_BITS-1:0];
				REG_SRC_HEIGHT:   cfg_q.src_height   <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_COS_COEF:     prdata = DATA_BITS'(cfg_q.cos_coef);
			REG_SIN_COEF:     prdata = DATA_BITS'(cfg_q.sin_coef);
			REG_DST_CENTER_X: prdata = DATA_BITS'(cfg_q.dst_center_x);
			REG_DST_CENTER_Y: prdata = DATA_BITS'(cfg_q.dst_center_y);
			REG_SRC_CENTER_X: prdata = DATA_BITS'(cfg_q.src_center_x);
			REG_SRC_CENTER_Y: prdata = DATA_BITS'(cfg_q.src_center_y);
			REG_SRC_WIDTH:    prdata = DATA_BITS'(cfg_q.src_width);
			REG_SRC_HEIGHT:   prdata = DATA_BITS'(cfg_q.src_height);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/rim_datapath.sv
module rim_datapath
	import rim_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  rim_cfg_t                     cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] dest_col,
	input  logic signed [COORD_BITS-1:0] dest_row,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         in_range,
	output logic [OUT_BITS-1:0]          source_col,
	output logic [OUT_BITS-1:0]          source_row
);

	// stage valids and per-stage ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: offsets from the destination centre
	logic signed [DIFF_BITS-1:0] dx_d, dy_d, dx_s1, dy_s1;

	assign dx_d = $signed({dest_col[COORD_BITS-1], dest_col})
		- $signed({cfg.dst_center_x[COORD_BITS-1], cfg.dst_center_x});
	assign dy_d = $signed({dest_row[COORD_BITS-1], dest_row})
		- $signed({cfg.dst_center_y[COORD_BITS-1], cfg.dst_center_y});

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			dx_s1 <= dx_d;
			dy_s1 <= dy_d;
		end
	end

	// stage 2: the four coefficient products
	logic signed [PROD_BITS-1:0] cx_d, cy_d, sx_d, sy_d;
	logic signed [PROD_BITS-1:0] cx_s2, cy_s2, sx_s2, sy_s2;

	always_comb begin
		cx_d = $signed(cfg.cos_coef) * dx_s1;
		cy_d = $signed(cfg.cos_coef) * dy_s1;
		sx_d = $signed(cfg.sin_coef) * dx_s1;
		sy_d = $signed(cfg.sin_coef) * dy_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			cx_s2 <= cx_d;
			cy_s2 <= cy_d;
			sx_s2 <= sx_d;
			sy_s2 <= sy_d;
		end
	end

	// stage 3: rotated offsets, still scaled
	logic signed [SUM_BITS-1:0] row_sum_d, col_sum_d, row_sum_s3, col_sum_s3;

	assign row_sum_d = $signed({cy_s2[PROD_BITS-1], cy_s2})
		- $signed({sx_s2[PROD_BITS-1], sx_s2});
	assign col_sum_d = $signed({sy_s2[PROD_BITS-1], sy_s2})
		+ $signed({cx_s2[PROD_BITS-1], cx_s2});

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			row_sum_s3 <= row_sum_d;
			col_sum_s3 <= col_sum_d;
		end
	end

	// stage 4: divide toward zero, then add the source centre
	logic [SUM_BITS-1:0]         row_bias, col_bias;
	logic [SUM_BITS-1:0]         row_adj, col_adj;
	logic [QUO_BITS-1:0]         row_quo, col_quo;
	logic signed [POS_BITS-1:0]  row_d, col_d, row_s4, col_s4;

	always_comb begin
		row_bias = row_sum_s3[SUM_BITS-1] ? SUM_BITS'(TRIG_SCALE - 1) : '0;
		col_bias = col_sum_s3[SUM_BITS-1] ? SUM_BITS'(TRIG_SCALE - 1) : '0;
		row_adj  = row_sum_s3 + row_bias;
		col_adj  = col_sum_s3 + col_bias;
		row_quo  = row_adj[SUM_BITS-1:TRIG_SHIFT];
		col_quo  = col_adj[SUM_BITS-1:TRIG_SHIFT];
		row_d    = $signed({row_quo[QUO_BITS-1], row_quo})
			+ $signed({{(POS_BITS-COORD_BITS){cfg.src_center_y[COORD_BITS-1]}},
				cfg.src_center_y});
		col_d    = $signed({col_quo[QUO_BITS-1], col_quo})
			+ $signed({{(POS_BITS-COORD_BITS){cfg.src_center_x[COORD_BITS-1]}},
				cfg.src_center_x});
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			row_s4 <= row_d;
			col_s4 <= col_d;
		end
	end

	// stage 5: bounds check against the clamped source size
	logic [COORD_BITS-1:0] w_lim, h_lim;
	logic                  col_ok, row_ok, ok_d;
	logic                  in_range_s5;
	logic [OUT_BITS-1:0]   source_col_s5, source_row_s5;

	always_comb begin
		w_lim  = (cfg.src_width > COORD_BITS'(MAX_SIZE)) ? COORD_BITS'(MAX_SIZE)
			: cfg.src_width;
		h_lim  = (cfg.src_height > COORD_BITS'(MAX_SIZE)) ? COORD_BITS'(MAX_SIZE)
			: cfg.src_height;
		col_ok = !col_s4[POS_BITS-1]
			&& (col_s4[POS_BITS-2:0] < (POS_BITS-1)'(w_lim));
		row_ok = !row_s4[POS_BITS-1]
			&& (row_s4[POS_BITS-2:0] < (POS_BITS-1)'(h_lim));
		ok_d   = col_ok && row_ok;
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			in_range_s5   <= ok_d;
			source_col_s5 <= ok_d ? col_s4[OUT_BITS-1:0] : '0;
			source_row_s5 <= ok_d ? row_s4[OUT_BITS-1:0] : '0;
		end
	end

	assign out_valid  = v_s5;
	assign in_range   = in_range_s5;
	assign source_col = source_col_s5;
	assign source_row = source_row_s5;

endmodule

// File: hw/rtl/rotate_inverse_coordinate_map.sv
// Maps each destination pixel (dest_col, dest_row) to a source pixel (truncated toward
// zero) under a rotation set by the cos_coef/sin_coef registers (scaled by 1024) about
// the programmed destination and source centres, with in_range low and zero coordinates
// for points outside the source size (sizes above 2048 count as 2048). One item is
// accepted every clock while in_ready is high; each item passes through a
// five-stage pipeline (centre offset, four 16x13 multiplies, sums, truncating divide plus
// source centre, bounds check) in which each stage advances on its own, so back-pressure
// on the output only stalls the input once every stage is full. Program the registers
// while no item is in flight.
module rotate_inverse_coordinate_map
	import rim_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_BITS-1:0]         paddr,
	input  logic [DATA_BITS-1:0]         pwdata,
	output logic [DATA_BITS-1:0]         prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] dest_col,
	input  logic signed [COORD_BITS-1:0] dest_row,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         in_range,
	output logic [OUT_BITS-1:0]          source_col,
	output logic [OUT_BITS-1:0]          source_row
);

	rim_cfg_t cfg;

	// configuration registers
	rim_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// coordinate pipeline
	rim_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.dest_col   (dest_col),
		.dest_row   (dest_row),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.in_range   (in_range),
		.source_col (source_col),
		.source_row (source_row)
	);

`ifndef SYNTHESIS
	// an item outside the source carries zero coordinates
	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_range) |-> (source_col == '0 && source_row == '0))
		else $error("out-of-range item with nonzero coordinates");

	// the input only stalls when the whole pipeline is backed up from the output
	a_stall_origin: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output back-pressure");

	// a result held under back-pressure keeps its values
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(in_range)
			&& $stable(source_col) && $stable(source_row)))
		else $error("pending result changed before it was taken");
`endif

endmodule
